// ===== hdl/skl_pkg.sv =====
`default_nettype none

package skl_pkg;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] mid;
		logic [31:0] lo;
	} key_t;

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_FIND   = 3'd2,
		REQ_READ   = 3'd3,
		REQ_SIZE   = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture the request
		logic cmp;   // register the per-slot compare flags
		logic exec;  // update the list and load the result register
	} skl_cmd_t;

	localparam int unsigned READ_SLOTS = 16;

endpackage

`default_nettype wire

// ===== hdl/skl_ctrl.sv =====
`default_nettype none

module skl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output skl_pkg::skl_cmd_t      cmd
);

	skl_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            exec_go;
	logic            accept;

	// Result register is free, or being emptied this cycle
	assign exec_go  = (state_q == skl_pkg::S_EXEC) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == skl_pkg::S_IDLE) || exec_go;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			skl_pkg::S_IDLE: begin
				if (accept) state_d = skl_pkg::S_CMP;
			end
			skl_pkg::S_CMP: begin
				state_d = skl_pkg::S_EXEC;
			end
			skl_pkg::S_EXEC: begin
				if (exec_go) state_d = accept ? skl_pkg::S_CMP : skl_pkg::S_IDLE;
			end
			default: begin
				state_d = skl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = accept;
		cmd.cmp  = (state_q == skl_pkg::S_CMP);
		cmd.exec = exec_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skl_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/skl_dp.sv =====
`default_nettype none

module skl_dp #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire skl_pkg::skl_cmd_t cmd,
	input  wire logic [2:0]        req_type,
	input  wire logic [63:0]       key_hi,
	input  wire logic [63:0]       key_mid,
	input  wire logic [31:0]       key_lo,
	input  wire logic [3:0]        index,
	output logic [1:0]             status,
	output logic [3:0]             found_index,
	output logic [4:0]             count,
	output logic [63:0]            entry_hi,
	output logic [63:0]            entry_mid,
	output logic [31:0]            entry_lo
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned RD_N  = (CAPACITY < skl_pkg::READ_SLOTS) ? CAPACITY
	                                                                : skl_pkg::READ_SLOTS;

	// Request register
	logic [2:0]    req_q;
	skl_pkg::key_t key_q;
	logic [3:0]    idx_q;

	// Slot row and list length
	skl_pkg::key_t      cell_q [CAPACITY];
	logic [CNT_W-1:0]   cnt_q;

	// Per-slot compare flags: slot at or above the key (empty slots count as above)
	logic [CAPACITY-1:0] ge_s1;
	logic [CAPACITY-1:0] eq_s1;

	// Result register
	logic [1:0]    status_q;
	logic [3:0]    found_q;
	logic [4:0]    count_q;
	skl_pkg::key_t entry_q;

	logic [CAPACITY-1:0] ge_prev;
	logic [CAPACITY-1:0] first;
	logic [IDX_W-1:0]    pos;
	logic                hit;
	logic                full;
	logic                ins_go;
	logic                rem_go;
	logic                in_range;
	skl_pkg::key_t       rd_key;
	logic [CNT_W-1:0]    cnt_d;
	logic [1:0]          status_d;
	logic [3:0]          found_d;
	skl_pkg::key_t       entry_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= '{hi: key_hi, mid: key_mid, lo: key_lo};
			idx_q <= index;
		end
	end

	// Boundary of the sorted thermometer code gives the insert / match position
	always_comb begin
		ge_prev[0] = 1'b0;
		for (int unsigned i = 1; i < CAPACITY; i++) ge_prev[i] = ge_s1[i-1];
		first = ge_s1 & ~ge_prev;
		pos = '0;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			if (first[i]) pos = pos | IDX_W'(i);
		end
		hit = |(first & eq_s1);
	end

	always_comb begin
		rd_key = '0;
		for (int unsigned i = 0; i < RD_N; i++) begin
			if (idx_q == 4'(i)) rd_key = cell_q[i];
		end
	end

	assign full     = (32'(cnt_q) >= 32'(CAPACITY));
	assign in_range = (32'(idx_q) < 32'(cnt_q));

	always_comb begin
		ins_go   = 1'b0;
		rem_go   = 1'b0;
		cnt_d    = cnt_q;
		status_d = skl_pkg::ST_OK;
		found_d  = '0;
		entry_d  = '0;
		case (skl_pkg::req_t'(req_q))
			skl_pkg::REQ_INSERT: begin
				if (full) begin
					status_d = skl_pkg::ST_FULL;
				end else begin
					ins_go  = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
					found_d = 4'(pos);
				end
			end
			skl_pkg::REQ_REMOVE: begin
				if (hit) begin
					rem_go  = 1'b1;
					cnt_d   = cnt_q - CNT_W'(1);
					found_d = 4'(pos);
				end else begin
					status_d = skl_pkg::ST_NOT_FOUND;
				end
			end
			skl_pkg::REQ_FIND: begin
				if (hit) found_d = 4'(pos);
				else status_d = skl_pkg::ST_NOT_FOUND;
			end
			skl_pkg::REQ_READ: begin
				found_d = idx_q;
				if (in_range) entry_d = rd_key;
				else status_d = skl_pkg::ST_RANGE;
			end
			skl_pkg::REQ_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
		skl_pkg::key_t ins_val;
		skl_pkg::key_t dn_val;

		if (g == 0) begin : g_first
			assign ins_val = key_q;
		end else begin : g_rest
			assign ins_val = ge_s1[g-1] ? cell_q[g-1] : key_q;
		end

		if (g == CAPACITY - 1) begin : g_last
			assign dn_val = cell_q[g];
		end else begin : g_body
			assign dn_val = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.cmp) begin
				ge_s1[g] <= (CNT_W'(g) >= cnt_q) || (cell_q[g] >= key_q);
				eq_s1[g] <= (CNT_W'(g) < cnt_q) && (cell_q[g] == key_q);
			end
			if (cmd.exec && ge_s1[g]) begin
				if (ins_go) cell_q[g] <= ins_val;
				else if (rem_go) cell_q[g] <= dn_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			found_q  <= found_d;
			count_q  <= 5'(cnt_d);
			entry_q  <= entry_d;
		end
	end

	assign status      = status_q;
	assign found_index = found_q;
	assign count       = count_q;
	assign entry_hi    = entry_q.hi;
	assign entry_mid   = entry_q.mid;
	assign entry_lo    = entry_q.lo;

endmodule

`default_nettype wire

// ===== hdl/sorted_key_list_core.sv =====
// Sorted key list: keeps up to CAPACITY 160-bit keys in ascending order.
// Input channel (in_valid / in_ready) carries one request per transaction:
// req_type selects insert, remove, find, read at index, size or clear;
// key_hi / key_mid / key_lo form the key, index the position for reads.
// Output channel (out_valid / out_ready) returns exactly one result per
// request: status, found_index, count after the request and, for a good
// read, the entry.
// Each request passes through the compare cycle (every slot against the key,
// flags registered) and then the update cycle (shift the slot row, load the
// result register); the next request can be accepted during the update
// cycle of the one before.
// While a result waits, the next request is still accepted and compared;
// its update cycle holds until the result register is taken.
// Reset clears the list length and both handshake states; slot contents
// stay as they are and are never read beyond the current length.
`default_nettype none

module sorted_key_list_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [63:0] key_hi,
	input  wire logic [63:0] key_mid,
	input  wire logic [31:0] key_lo,
	input  wire logic [3:0]  index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [3:0]       found_index,
	output logic [4:0]       count,
	output logic [63:0]      entry_hi,
	output logic [63:0]      entry_mid,
	output logic [31:0]      entry_lo
);

	skl_pkg::skl_cmd_t cmd;

	// Sequence each request through capture, compare and update
	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Slot row with one comparator per slot, shift logic and result register
	skl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.key_hi      (key_hi),
		.key_mid     (key_mid),
		.key_lo      (key_lo),
		.index       (index),
		.status      (status),
		.found_index (found_index),
		.count       (count),
		.entry_hi    (entry_hi),
		.entry_mid   (entry_mid),
		.entry_lo    (entry_lo)
	);

endmodule

`default_nettype wire

// ===== tb/tb_sorted_key_list_core.sv =====
module tb_sorted_key_list_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY = 16;

	// Request codes past the last real operation; the block must treat them as no-ops
	localparam logic [2:0] REQ_UNUSED_A = 3'd6;
	localparam logic [2:0] REQ_UNUSED_B = 3'd7;

	localparam int unsigned ITEMS_PER_PHASE = 540;
	localparam int unsigned STALL_LIMIT     = 2000;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned MAX_PRINTED     = 40;

	// Directed keys: a mixed key with a zero byte in the middle and stray bytes after it,
	// and a neighbor that differs from it only in the last bit of the low word
	localparam bit [159:0] KEY_MIXED    = {64'h4142_4344_0046_4748, 64'h8000_0000_0000_0001,
		32'hFFFF_0000};
	localparam bit [159:0] KEY_NEIGHBOR = KEY_MIXED ^ 160'd1;
	localparam bit [159:0] KEY_ZERO     = '0;
	localparam bit [159:0] KEY_ONES     = '1;

	// One result transaction, packed in port order: status, index, count, entry words
	typedef struct packed {
		logic [1:0]   status;
		logic [3:0]   pos;
		logic [4:0]   count;
		logic [159:0] entry;
	} list_result_t;

	// Scoreboard: holds a private copy of the sorted list, turns each accepted request
	// into the result it must produce, and checks results in order against that queue.
	class key_list_scoreboard;
		bit [159:0]   slot [CAPACITY];
		int unsigned  fill;
		list_result_t pending_results [$];
		int unsigned  mismatches;
		int unsigned  checked;

		function void note_request(logic [2:0] req, bit [159:0] key, logic [3:0] idx);
			list_result_t r;
			int unsigned  pos;
			int unsigned  i;
			r   = '0;
			pos = 0;
			case (req)
			skl_pkg::REQ_INSERT: begin
				if (fill >= CAPACITY) begin
					r.status = skl_pkg::ST_FULL;
				end else begin
					// land in front of the first entry that is not below the key
					while (pos < fill && slot[pos] < key)
						pos++;
					for (i = fill; i > pos; i--)
						slot[i] = slot[i - 1];
					slot[pos] = key;
					fill++;
				end
			end
			skl_pkg::REQ_REMOVE, skl_pkg::REQ_FIND: begin
				while (pos < fill && slot[pos] != key)
					pos++;
				if (pos == fill) begin
					r.status = skl_pkg::ST_NOT_FOUND;
					pos      = 0;
				end else if (req == skl_pkg::REQ_REMOVE) begin
					for (i = pos; i + 1 < fill; i++)
						slot[i] = slot[i + 1];
					fill--;
				end
			end
			skl_pkg::REQ_READ: begin
				pos = idx;
				if (idx >= fill)
					r.status = skl_pkg::ST_RANGE;
				else
					r.entry = slot[idx];
			end
			skl_pkg::REQ_CLEAR: begin
				fill = 0;
			end
			default: begin
			end
			endcase
			r.pos   = pos[3:0];
			r.count = fill[4:0];
			pending_results.push_back(r);
		endfunction

		task report(string field, logic [159:0] got, logic [159:0] want);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("%0t ns: result %0d, %s: got %h, expected %h",
					$time, checked, field, got, want);
		endtask

		task check_result(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				report("result with no request waiting", got, '0);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.status !== want.status)
				report("status", got.status, want.status);
			if (got.pos !== want.pos)
				report("found_index", got.pos, want.pos);
			if (got.count !== want.count)
				report("count", got.count, want.count);
			if (got.entry[159:96] !== want.entry[159:96])
				report("entry_hi", got.entry[159:96], want.entry[159:96]);
			if (got.entry[95:32] !== want.entry[95:32])
				report("entry_mid", got.entry[95:32], want.entry[95:32]);
			if (got.entry[31:0] !== want.entry[31:0])
				report("entry_lo", got.entry[31:0], want.entry[31:0]);
		endtask
	endclass

	// Every block input starts at a known value; reset is held from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        out_ready = 1'b0;
	logic [2:0]  req_type  = '0;
	logic [63:0] key_hi    = '0;
	logic [63:0] key_mid   = '0;
	logic [31:0] key_lo    = '0;
	logic [3:0]  index     = '0;

	logic        in_ready;
	logic        out_valid;
	logic [1:0]  status;
	logic [3:0]  found_index;
	logic [4:0]  count;
	logic [63:0] entry_hi;
	logic [63:0] entry_mid;
	logic [31:0] entry_lo;

	// Idle odds in percent for each side; the stimulus changes them per phase
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned stall_cycles  = 0;

	key_list_scoreboard sb = new();

	sorted_key_list_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key_hi     (key_hi),
		.key_mid    (key_mid),
		.key_lo     (key_lo),
		.index      (index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found_index(found_index),
		.count      (count),
		.entry_hi   (entry_hi),
		.entry_mid  (entry_mid),
		.entry_lo   (entry_lo)
	);

	initial begin : clock_gen
		forever #6 clk = ~clk;
	end

	// Pick a key for the next request. Favor keys already in the list and their close
	// neighbors so finds and removes hit and the compare has to look at every word.
	function automatic bit [159:0] pick_key();
		int unsigned sel;
		int unsigned len;
		int unsigned b;
		int unsigned bitpos;
		bit [159:0]  k;
		sel = $urandom_range(9);
		k   = '0;
		if (sb.fill != 0 && sel < 4) begin
			k = sb.slot[$urandom_range(sb.fill - 1)];
			if (sel == 3) begin
				case ($urandom_range(3))
				0: begin
					bitpos    = $urandom_range(159);
					k[bitpos] = ~k[bitpos];
				end
				1: k = k + 160'd1;
				2: k = k - 160'd1;
				default: k[31:0] = $urandom;
				endcase
			end
		end else if (sel < 6) begin
			// printable string of 0 to 20 bytes, zero padded
			len = $urandom_range(20);
			for (b = 0; b < len; b++)
				k[159 - 8 * b -: 8] = 8'($urandom_range(126, 32));
		end else if (sel == 6) begin
			// each word at one of its extremes
			k[159:96] = $urandom_range(1) ? '1 : '0;
			k[95:32]  = $urandom_range(1) ? '1 : '0;
			k[31:0]   = $urandom_range(1) ? '1 : '0;
		end else begin
			k = {$urandom, $urandom, $urandom, $urandom, $urandom};
		end
		return k;
	endfunction

	// Read index: half the time a live position, otherwise anywhere in the field
	function automatic logic [3:0] next_index();
		if (sb.fill != 0 && $urandom_range(1))
			return 4'($urandom_range(sb.fill - 1));
		return 4'($urandom_range(15));
	endfunction

	// Offer one request and hold it until the block takes it. Entered and left just
	// after a rising edge, so each signal gets one nonblocking write per edge.
	task automatic send_item(logic [2:0] req, bit [159:0] key, logic [3:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		key_hi   <= key[159:96];
		key_mid  <= key[95:32];
		key_lo   <= key[31:0];
		index    <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(req, key, idx);
	endtask

	// Drop valid and wait until every expected result has been taken
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Random traffic, insert-heavy so the list fills up; now and then a straight run of
	// inserts drives it past full
	task automatic run_random(int unsigned items);
		int unsigned sent;
		int unsigned sel;
		int unsigned k;
		logic [2:0]  req;
		sent = 0;
		while (sent < items) begin
			sel = $urandom_range(99);
			if (sel == 0) begin
				for (k = 0; k < CAPACITY + 2; k++)
					send_item(skl_pkg::REQ_INSERT, pick_key(), next_index());
				sent += CAPACITY + 2;
			end else begin
				if (sel < 45)
					req = skl_pkg::REQ_INSERT;
				else if (sel < 58)
					req = skl_pkg::REQ_REMOVE;
				else if (sel < 72)
					req = skl_pkg::REQ_FIND;
				else if (sel < 87)
					req = skl_pkg::REQ_READ;
				else if (sel < 93)
					req = skl_pkg::REQ_SIZE;
				else if (sel < 96)
					req = skl_pkg::REQ_CLEAR;
				else if (sel < 98)
					req = REQ_UNUSED_A;
				else
					req = REQ_UNUSED_B;
				send_item(req, pick_key(), next_index());
				sent++;
			end
		end
	endtask

	// Result side: check each completed transaction, then pick ready for the next edge
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result({status, found_index, count, entry_hi, entry_mid, entry_lo});
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count edges with work outstanding but no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else if (in_valid || sb.pending_results.size() != 0)
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles often, receiver idles more
		send_idle_pct = 35;
		recv_idle_pct = 58;

		// Directed: empty-list corner cases first
		send_item(skl_pkg::REQ_SIZE, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_REMOVE, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_FIND, KEY_ONES, 4'd15);
		// Extreme keys, a duplicate that must land ahead of its twin, a one-bit neighbor
		send_item(skl_pkg::REQ_INSERT, KEY_ONES, 4'd0);
		send_item(skl_pkg::REQ_INSERT, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_INSERT, KEY_MIXED, 4'd0);
		send_item(skl_pkg::REQ_INSERT, KEY_MIXED, 4'd0);
		send_item(skl_pkg::REQ_INSERT, KEY_NEIGHBOR, 4'd0);
		send_item(skl_pkg::REQ_FIND, KEY_MIXED, 4'd0);
		send_item(skl_pkg::REQ_FIND, KEY_NEIGHBOR, 4'd0);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd2);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd4);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd5);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd15);
		send_item(skl_pkg::REQ_REMOVE, KEY_MIXED, 4'd0);
		send_item(skl_pkg::REQ_REMOVE, KEY_ONES, 4'd0);
		send_item(REQ_UNUSED_A, KEY_ONES, 4'd15);
		send_item(REQ_UNUSED_B, KEY_ZERO, 4'd0);
		// Clear leaves stale slots; a read must still report out of range
		send_item(skl_pkg::REQ_CLEAR, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_READ, KEY_ZERO, 4'd0);
		send_item(skl_pkg::REQ_SIZE, KEY_ZERO, 4'd0);

		run_random(ITEMS_PER_PHASE);
		hold_until_drained();

		// Phase two: swap the idle odds
		send_idle_pct = 58;
		recv_idle_pct = 35;
		run_random(ITEMS_PER_PHASE);
		hold_until_drained();

		// Phase three: full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(ITEMS_PER_PHASE);
		hold_until_drained();

		// Let any stray result show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/skl_pkg.sv
hdl/skl_ctrl.sv
hdl/skl_dp.sv
hdl/sorted_key_list_core.sv
tb/tb_sorted_key_list_core.sv
